// ----- design/ordered_key_value_table_core_defines.svh -----
// assertion macros for the ordered key-value table core
// used by the top level only, no other dependencies
`ifndef ORDERED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define OKVT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define OKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/okvt_pkg.sv -----
// shared types and constants for the ordered key-value table core
// no dependencies
`timescale 1ns / 1ps

package okvt_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // item field widths on the stream ports
  localparam int unsigned OP_W          = 3;
  localparam int unsigned KEY_FIELD_W   = 32;
  localparam int unsigned VALUE_FIELD_W = 32;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned TOTAL_W       = 5;

  localparam int unsigned IN_BITS  = OP_W + KEY_FIELD_W + VALUE_FIELD_W + POS_W;
  localparam int unsigned OUT_BITS = 1 + KEY_FIELD_W + VALUE_FIELD_W + TOTAL_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_UPSERT   = 3'd2,
    OP_ERASE    = 3'd3,
    OP_LOOKUP   = 3'd4,
    OP_READ_POS = 3'd5,
    OP_COUNT    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDPOS,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [POS_W-1:0]      pos;
  } item_t;

  typedef struct packed {
    logic                  ok;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      total;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [IDX_W-1:0]      raddr;
    logic [KEY_BITS-1:0]   wkey;
    logic [VALUE_BITS-1:0] wval;
  } store_req_t;

endpackage

// ----- design/okvt_store.sv -----
// entry memory: key and value arrays, one write and one registered read per cycle
// depends on okvt_pkg
`timescale 1ns / 1ps

module okvt_store (
  input  logic                            clk_i,
  input  okvt_pkg::store_req_t            req_i,
  output logic [okvt_pkg::KEY_BITS-1:0]   rkey_o,
  output logic [okvt_pkg::VALUE_BITS-1:0] rval_o
);
  import okvt_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      key_mem[req_i.waddr] <= req_i.wkey;
      val_mem[req_i.waddr] <= req_i.wval;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[req_i.raddr];
    rval_o <= val_mem[req_i.raddr];
  end

endmodule

// ----- design/okvt_seq.sv -----
// sequencer: scans the entry memory through one key comparator and moves
// entries one per cycle on insert and erase; depends on okvt_pkg
`timescale 1ns / 1ps

module okvt_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_vld_i,
  output logic                            item_rdy_o,
  input  okvt_pkg::item_t                 item_i,
  output logic                            res_vld_o,
  input  logic                            res_rdy_i,
  output okvt_pkg::res_t                  res_o,
  output okvt_pkg::store_req_t            store_req_o,
  input  logic [okvt_pkg::KEY_BITS-1:0]   rkey_i,
  input  logic [okvt_pkg::VALUE_BITS-1:0] rval_i
);
  import okvt_pkg::*;

  state_e state_q, state_d;

  // control state
  logic [CNT_W-1:0] occ_q, occ_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             pend_q, pend_d;

  // per-item working registers
  op_e                   op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]      sh_q, sh_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [IDX_W-1:0]      pend_addr_q, pend_addr_d;
  logic                  dir_up_q, dir_up_d;
  logic                  ok_q, ok_d;
  logic [KEY_BITS-1:0]   kout_q, kout_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;

  logic hit, miss, full, ins_start, shift_end;

  // the shared comparator: data read last cycle against the item key
  assign hit       = cmp_vld_q && (rkey_i == key_q);
  assign miss      = !cmp_vld_q && (scan_q >= occ_q);
  assign full      = (occ_q == CNT_W'(CAPACITY));
  assign ins_start = miss && !full && (op_q inside {OP_INSERT, OP_UPSERT});
  assign shift_end = (rem_q == '0) && !pend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_vld_i) begin
          case (item_i.op) inside
            OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP: state_d = ST_SCAN;
            OP_READ_POS: state_d = ST_RDPOS;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = (op_q == OP_ERASE) ? ST_SHIFT : ST_DONE;
        end else if (ins_start) begin
          state_d = ST_SHIFT;
        end else if (miss) begin
          state_d = ST_DONE;
        end
      end
      ST_RDPOS: state_d = ST_DONE;
      ST_SHIFT: begin
        if (shift_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_rdy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_d       = occ_q;
    cmp_vld_d   = cmp_vld_q;
    pend_d      = pend_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    cmp_idx_d   = cmp_idx_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    pend_addr_d = pend_addr_q;
    dir_up_d    = dir_up_q;
    ok_d        = ok_q;
    kout_d      = kout_q;
    vout_d      = vout_q;
    item_rdy_o  = 1'b0;
    res_vld_o   = 1'b0;
    store_req_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        item_rdy_o        = 1'b1;
        store_req_o.raddr = IDX_W'(item_i.pos);
        if (item_vld_i) begin
          op_d      = item_i.op;
          key_d     = item_i.key;
          val_d     = item_i.value;
          pos_d     = item_i.pos;
          kout_d    = item_i.key;
          vout_d    = '0;
          ok_d      = (item_i.op == OP_COUNT);
          scan_d    = '0;
          cmp_vld_d = 1'b0;
          pend_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        if (scan_q < occ_q) begin
          store_req_o.raddr = scan_q[IDX_W-1:0];
          scan_d            = scan_q + CNT_W'(1);
          cmp_vld_d         = 1'b1;
          cmp_idx_d         = scan_q[IDX_W-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (hit) begin
          case (op_q) inside
            OP_UPDATE, OP_UPSERT: begin
              store_req_o.we    = 1'b1;
              store_req_o.waddr = cmp_idx_q;
              store_req_o.wkey  = key_q;
              store_req_o.wval  = val_q;
              ok_d              = 1'b1;
            end
            OP_ERASE: begin
              dir_up_d = 1'b1;
              sh_d     = cmp_idx_q + IDX_W'(1);
              rem_d    = occ_q - CNT_W'(cmp_idx_q) - CNT_W'(1);
              ok_d     = 1'b1;
            end
            OP_LOOKUP: begin
              vout_d = rval_i;
              ok_d   = 1'b1;
            end
            default: ok_d = 1'b0;
          endcase
        end else if (ins_start) begin
          dir_up_d = 1'b0;
          sh_d     = IDX_W'(occ_q - CNT_W'(1));
          rem_d    = occ_q;
        end
      end
      ST_RDPOS: begin
        if (CNT_W'(pos_q) < occ_q) begin
          ok_d   = 1'b1;
          kout_d = rkey_i;
          vout_d = rval_i;
        end
      end
      ST_SHIFT: begin
        // read one entry, write it one place over in the next cycle
        if (rem_q != '0) begin
          store_req_o.raddr = sh_q;
          sh_d              = dir_up_q ? sh_q + IDX_W'(1) : sh_q - IDX_W'(1);
          rem_d             = rem_q - CNT_W'(1);
          pend_d            = 1'b1;
          pend_addr_d       = dir_up_q ? sh_q - IDX_W'(1) : sh_q + IDX_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          store_req_o.we    = 1'b1;
          store_req_o.waddr = pend_addr_q;
          store_req_o.wkey  = rkey_i;
          store_req_o.wval  = rval_i;
        end else if (shift_end) begin
          if (dir_up_q) begin
            occ_d = occ_q - CNT_W'(1);
          end else begin
            store_req_o.we    = 1'b1;
            store_req_o.waddr = '0;
            store_req_o.wkey  = key_q;
            store_req_o.wval  = val_q;
            occ_d             = occ_q + CNT_W'(1);
            ok_d              = 1'b1;
          end
        end
      end
      ST_DONE: res_vld_o = 1'b1;
      default: res_vld_o = 1'b0;
    endcase
  end

  assign res_o.ok    = ok_q;
  assign res_o.key   = kout_q;
  assign res_o.value = vout_q;
  assign res_o.total = occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      occ_q     <= '0;
      cmp_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      cmp_vld_q <= cmp_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    scan_q      <= scan_d;
    cmp_idx_q   <= cmp_idx_d;
    sh_q        <= sh_d;
    rem_q       <= rem_d;
    pend_addr_q <= pend_addr_d;
    dir_up_q    <= dir_up_d;
    ok_q        <= ok_d;
    kout_q      <= kout_d;
    vout_q      <= vout_d;
  end

endmodule

// ----- design/ordered_key_value_table_core.sv -----
// count and bad codes go straight to the result, read by position reads one entry;
// lookup, update and failed ops scan the entries, erase then moves the later entries
// forward and insert moves every entry back; one item at a time: the single memory
// read port and the one key comparator walk the entries one per cycle
// reset: entry count cleared at once, entry memory left as is, no clearing pass
// depends on okvt_pkg, okvt_store, okvt_seq and the assertion macro header
`timescale 1ns / 1ps
`include "ordered_key_value_table_core_defines.svh"

module ordered_key_value_table_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation, key_in, value_in, position, zero pad
  input  logic [okvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // ok, key_out, value_out, entry_total, zero pad
  output logic [okvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import okvt_pkg::*;

  localparam int unsigned KEY_OFS   = OP_W;
  localparam int unsigned VALUE_OFS = KEY_OFS + KEY_FIELD_W;
  localparam int unsigned POS_OFS   = VALUE_OFS + VALUE_FIELD_W;

  item_t      item;
  res_t       res;
  store_req_t store_req;
  logic       res_vld, res_rdy;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  logic out_vld_q, out_vld_d;
  res_t out_res_q;

  assign item.op    = op_e'(s_axis_tdata[OP_W-1:0]);
  assign item.key   = KEY_BITS'(s_axis_tdata[KEY_OFS +: KEY_FIELD_W]);
  assign item.value = VALUE_BITS'(s_axis_tdata[VALUE_OFS +: VALUE_FIELD_W]);
  assign item.pos   = s_axis_tdata[POS_OFS +: POS_W];

  okvt_store u_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .rkey_o (rkey),
    .rval_o (rval)
  );

  okvt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_vld_i  (s_axis_tvalid),
    .item_rdy_o  (s_axis_tready),
    .item_i      (item),
    .res_vld_o   (res_vld),
    .res_rdy_i   (res_rdy),
    .res_o       (res),
    .store_req_o (store_req),
    .rkey_i      (rkey),
    .rval_i      (rval)
  );

  // output register frees the sequencer while the result waits
  assign res_rdy = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_vld && res_rdy) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && res_rdy) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({TOTAL_W'(out_res_q.total),
                                       VALUE_FIELD_W'(out_res_q.value),
                                       KEY_FIELD_W'(out_res_q.key),
                                       out_res_q.ok});

  `OKVT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "block took an item while busy")
  `OKVT_ASSERT_NEXT(a_result_registered, clk_i, rst_ni, res_vld && res_rdy, m_axis_tvalid, "finished result did not reach the output")
  `OKVT_ASSERT_SAME(a_total_in_range, clk_i, rst_ni, m_axis_tvalid, out_res_q.total <= CNT_W'(CAPACITY), "entry count above capacity")

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the ordered key-value table core
// keeps a shadow copy of the table and checks every result against it
// depends on okvt_pkg and ordered_key_value_table_core
`timescale 1ns / 1ps

module testbench;
  import okvt_pkg::*;

  localparam int unsigned         CYCLE_LIMIT = 500000;
  localparam int unsigned         HOLD_CYCLES = 400;
  localparam int unsigned         DRAIN_WAIT  = 60;
  localparam int unsigned         POOL_SIZE   = 24;
  localparam int unsigned         POOL_IDX_W  = $clog2(POOL_SIZE);
  localparam logic [OP_W-1:0]     OP_UNUSED   = 3'd7;
  localparam logic [KEY_BITS-1:0] ALL_ONES    = '1;

  typedef struct packed {
    logic                     ok;
    logic [KEY_FIELD_W-1:0]   key;
    logic [VALUE_FIELD_W-1:0] value;
    logic [TOTAL_W-1:0]       total;
  } table_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow copy of the table, newest entry at index 0
  logic [KEY_BITS-1:0]    shadow_keys [CAPACITY];
  logic [VALUE_BITS-1:0]  shadow_vals [CAPACITY];
  int unsigned            shadow_count = 0;

  table_result_t          pending_results [$];
  logic [KEY_BITS-1:0]    key_pool [POOL_SIZE];
  int unsigned            fail_cnt = 0;
  int unsigned            cycle_cnt = 0;
  bit                     tx_idle = 1'b1;
  bit                     rx_idle = 1'b1;
  int unsigned            rx_hold = 0;

  ordered_key_value_table_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("ordered_key_value_table_core verification failed");
      $finish;
    end
  end

  function automatic int find_shadow(input logic [KEY_BITS-1:0] key);
    int at;
    at = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (at < 0 && shadow_keys[i] == key) at = i;
    end
    return at;
  endfunction

  function automatic bit push_front(input logic [KEY_BITS-1:0] key,
                                    input logic [VALUE_BITS-1:0] val);
    if (shadow_count >= CAPACITY) return 1'b0;
    for (int i = shadow_count; i > 0; i--) begin
      shadow_keys[i] = shadow_keys[i-1];
      shadow_vals[i] = shadow_vals[i-1];
    end
    shadow_keys[0] = key;
    shadow_vals[0] = val;
    shadow_count++;
    return 1'b1;
  endfunction

  // applies one operation to the shadow table and returns the result it gives
  function automatic table_result_t predict_table_op(input logic [OP_W-1:0] op,
                                                     input logic [KEY_BITS-1:0] key,
                                                     input logic [VALUE_BITS-1:0] val,
                                                     input logic [POS_W-1:0] pos);
    table_result_t r;
    int at;
    r = '0;
    r.key = key;
    at = find_shadow(key);
    case (op)
      OP_INSERT: begin
        if (at < 0) r.ok = push_front(key, val);
      end
      OP_UPDATE: begin
        if (at >= 0) begin
          shadow_vals[at] = val;
          r.ok = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (at >= 0) begin
          shadow_vals[at] = val;
          r.ok = 1'b1;
        end else begin
          r.ok = push_front(key, val);
        end
      end
      OP_ERASE: begin
        if (at >= 0) begin
          for (int i = at; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (at >= 0) begin
          r.value = shadow_vals[at];
          r.ok = 1'b1;
        end
      end
      OP_READ_POS: begin
        if (pos < shadow_count) begin
          r.key = shadow_keys[pos];
          r.value = shadow_vals[pos];
          r.ok = 1'b1;
        end
      end
      OP_COUNT: r.ok = 1'b1;
      default: r.ok = 1'b0;
    endcase
    r.total = shadow_count[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] val, input logic [POS_W-1:0] pos);
    int unsigned gap;
    logic [IN_TDATA_W-1:0] word;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    word = '0;
    word[OP_W-1:0] = op;
    word[OP_W +: KEY_FIELD_W] = key;
    word[OP_W+KEY_FIELD_W +: VALUE_FIELD_W] = val;
    word[OP_W+KEY_FIELD_W+VALUE_FIELD_W +: POS_W] = pos;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_table_op(op, key, val, pos));
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 99) < 85)
      return key_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
    return $urandom;
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned r;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 22) op = OP_INSERT;
    else if (r < 34) op = OP_UPDATE;
    else if (r < 46) op = OP_UPSERT;
    else if (r < 64) op = OP_ERASE;
    else if (r < 78) op = OP_LOOKUP;
    else if (r < 92) op = OP_READ_POS;
    else if (r < 97) op = OP_COUNT;
    else op = OP_UNUSED;
    // mostly positions that hold an entry, some beyond
    if (shadow_count > 0 && $urandom_range(0, 3) != 0)
      pos = POS_W'($urandom_range(0, shadow_count - 1));
    else
      pos = POS_W'($urandom_range(0, 15));
    send_item(op, pick_key(), pick_value(), pos);
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(OP_COUNT, 32'h0000_0001, '1, '0);
    send_item(OP_READ_POS, 32'h1234_5678, '1, '0);
    send_item(OP_LOOKUP, ALL_ONES, '0, '1);
    send_item(OP_UPDATE, 32'h0, '1, '0);
    send_item(OP_ERASE, 32'h0, '0, '0);
    send_item(OP_INSERT, 32'h0, '1, '0);
    send_item(OP_INSERT, ALL_ONES, '0, '1);
    send_item(OP_INSERT, 32'h0, 32'h5555_5555, '0);   // duplicate key
    send_item(OP_UPDATE, 32'h0, 32'hAAAA_AAAA, '0);
    send_item(OP_UPSERT, ALL_ONES, 32'h8000_0001, '0);
    send_item(OP_UPSERT, 32'h7FFF_FFFE, 32'h1357_9BDF, '0);
    send_item(OP_LOOKUP, 32'h0, '0, '0);
    send_item(OP_READ_POS, '0, '0, 4'd0);
    send_item(OP_READ_POS, '0, '0, 4'd2);
    send_item(OP_READ_POS, ALL_ONES, '1, 4'd3);       // one past the last entry
    send_item(OP_READ_POS, ALL_ONES, '1, 4'd15);
    send_item(OP_ERASE, 32'h7FFF_FFFE, '0, '0);       // front entry
    send_item(OP_ERASE, 32'h0, '0, '0);               // last entry
    send_item(OP_UNUSED, ALL_ONES, '1, '1);
    send_item(OP_LOOKUP, ALL_ONES, '0, '0);
    send_item(OP_COUNT, '0, '0, '0);
  endtask

  // fill to capacity, poke at the full table, then drain in random order
  task automatic test_fill_drain(input int unsigned rounds);
    logic [KEY_BITS-1:0] k;
    for (int n = 0; n < rounds; n++) begin
      while (shadow_count < CAPACITY)
        send_item($urandom_range(0, 1) ? OP_INSERT : OP_UPSERT, $urandom, pick_value(), '0);
      send_item(OP_INSERT, $urandom, pick_value(), '0);
      send_item(OP_UPSERT, $urandom, pick_value(), '0);
      send_item(OP_UPSERT, shadow_keys[IDX_W'($urandom_range(0, CAPACITY - 1))],
                pick_value(), '0);
      send_item(OP_INSERT, shadow_keys[CAPACITY - 1], pick_value(), '0);
      for (int p = 0; p < CAPACITY; p++) send_item(OP_READ_POS, $urandom, $urandom, POS_W'(p));
      while (shadow_count > 0) begin
        k = shadow_keys[IDX_W'($urandom_range(0, shadow_count - 1))];
        if ($urandom_range(0, 3) == 0) send_item(OP_LOOKUP, k, $urandom, POS_W'($urandom));
        send_item(OP_ERASE, k, $urandom, POS_W'($urandom));
      end
      send_item(OP_ERASE, k, '0, '0);
    end
  endtask

  task automatic test_random_mix(input int unsigned items);
    for (int n = 0; n < items; n++) begin
      // change idle behavior every few dozen items
      if (n % 40 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      send_random_item();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering items back to back
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = HOLD_CYCLES;
    for (int n = 0; n < 30; n++) send_random_item();
    tx_idle = 1'b1;
  endtask

  // receiver side: random stalls per result plus an occasional long hold-off
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    table_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok    = m_axis_tdata[0];
      got.key   = m_axis_tdata[1 +: KEY_FIELD_W];
      got.value = m_axis_tdata[1+KEY_FIELD_W +: VALUE_FIELD_W];
      got.total = m_axis_tdata[1+KEY_FIELD_W+VALUE_FIELD_W +: TOTAL_W];
      if (pending_results.size() == 0) begin
        $error("unexpected item on result port: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          fail_cnt++;
        end
        if (got.key !== want.key) begin
          $error("key_out: expected %h, got %h", want.key, got.key);
          fail_cnt++;
        end
        if (got.value !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, got.value);
          fail_cnt++;
        end
        if (got.total !== want.total) begin
          $error("entry_total: expected %0d, got %0d", want.total, got.total);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_drain(3);
    test_random_mix(200);
    test_backpressure();
    test_random_mix(150);

    s_axis_tvalid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("ordered_key_value_table_core verification clean");
    end else begin
      $display("ordered_key_value_table_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/okvt_pkg.sv
design/okvt_store.sv
design/okvt_seq.sv
design/ordered_key_value_table_core.sv
verif/testbench.sv
